@@ sv/lut_1d_linear_interp_top_defines.svh @@
// Assertion macros used by the top level of the lookup table interpolator.
`ifndef LUT_1D_LINEAR_INTERP_TOP_DEFINES_SVH
`define LUT_1D_LINEAR_INTERP_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LJI_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lut_1d_linear_interp: assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define LJI_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lut_1d_linear_interp: assertion failed");

`endif

@@ sv/lji_pkg.sv @@
// Package with the shared types, codes and defaults of the lookup table interpolator.
package lji_pkg;

  // Default parameter values.
  localparam int unsigned LUT_DEPTH_DEF  = 1024;
  localparam int unsigned PIXEL_BITS_DEF = 16;

  // Configuration port geometry.
  localparam int unsigned CFG_IW = 1;
  localparam int unsigned CFG_DW = 16;

  // Register indexes.
  localparam logic [CFG_IW-1:0] REG_LOW_BOUND  = 1'b0;
  localparam logic [CFG_IW-1:0] REG_HIGH_BOUND = 1'b1;

  // Item operation codes.
  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_PIXEL = 1'b1
  } opcode_e;

  // Clipping status of a result.
  typedef enum logic [1:0] {
    CLIP_NONE = 2'd0,
    CLIP_LOW  = 2'd1,
    CLIP_HIGH = 2'd2
  } clip_e;

  // Input item.
  typedef struct packed {
    logic [0:0]  opcode;
    logic [9:0]  entry_index;
    logic [15:0] entry_value;
    logic [15:0] pixel;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [15:0] mapped_value;
    logic [1:0]  clip_status;
  } out_item_t;

endpackage

@@ sv/lji_index.sv @@
// Bound checks and table address and fraction calculation for one pixel.
module lji_index import lji_pkg::*; #(
  parameter int unsigned LUT_DEPTH  = LUT_DEPTH_DEF,
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF,
  localparam int unsigned AW = (LUT_DEPTH > 1) ? $clog2(LUT_DEPTH) : 1
) (
  input  logic [15:0]           pixel_i,
  input  logic [15:0]           low_bound_i,
  input  logic [15:0]           high_bound_i,
  output logic [AW-1:0]         x0_o,
  output logic [AW-1:0]         x1_o,
  output logic [PIXEL_BITS-1:0] frac_o,
  output clip_e                 clip_o
);

  // The integer part can exceed the table when the fraction is narrower than the pixel.
  localparam int unsigned XW = AW + 16;
  localparam int unsigned PW = PIXEL_BITS + XW;
  localparam logic [AW-1:0] LAST = AW'(LUT_DEPTH - 1);

  logic [PW-1:0] prod;
  logic [XW-1:0] x0_wide;
  logic [AW-1:0] x0_clamped;

  // Scale the pixel by the table depth and split off the fraction.
  assign prod       = PW'(pixel_i) * PW'(LUT_DEPTH);
  assign x0_wide    = prod[PW-1:PIXEL_BITS];
  assign x0_clamped = (x0_wide > XW'(LUT_DEPTH - 1)) ? LAST : x0_wide[AW-1:0];

  // Clipped pixels read a single end entry with a zero fraction.
  always_comb begin
    if (pixel_i <= low_bound_i) begin
      clip_o = CLIP_LOW;
      x0_o   = '0;
      x1_o   = '0;
      frac_o = '0;
    end else if (pixel_i >= high_bound_i) begin
      clip_o = CLIP_HIGH;
      x0_o   = LAST;
      x1_o   = LAST;
      frac_o = '0;
    end else begin
      clip_o = CLIP_NONE;
      x0_o   = x0_clamped;
      x1_o   = (x0_clamped == LAST) ? LAST : x0_clamped + AW'(1);
      frac_o = prod[PIXEL_BITS-1:0];
    end
  end

endmodule

@@ sv/lji_mem.sv @@
// Table memory with one write port and two registered read ports.
module lji_mem import lji_pkg::*; #(
  parameter int unsigned LUT_DEPTH = LUT_DEPTH_DEF,
  localparam int unsigned AW = (LUT_DEPTH > 1) ? $clog2(LUT_DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr0_i,
  input  logic [AW-1:0] raddr1_i,
  output logic [15:0]   rdata0_o,
  output logic [15:0]   rdata1_o
);

  logic [15:0] mem_q [LUT_DEPTH];
  logic [15:0] rd0_q;
  logic [15:0] rd1_q;

  // Entry store; entries hold nothing meaningful until written.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Both neighbours are read together and held until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd0_q <= mem_q[raddr0_i];
      rd1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rd0_q;
  assign rdata1_o = rd1_q;

endmodule

@@ sv/lji_interp.sv @@
// Linear interpolation between two neighbouring table entries, rounded down.
module lji_interp import lji_pkg::*; #(
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic [15:0]           y0_i,
  input  logic [15:0]           y1_i,
  input  logic [PIXEL_BITS-1:0] frac_i,
  output logic [15:0]           result_o
);

  localparam int unsigned MW = PIXEL_BITS + 18;

  logic signed [16:0]   diff;
  logic signed [MW-1:0] prod;
  logic signed [MW-1:0] sum;

  // y0 + floor(f * (y1 - y0) / 2^PIXEL_BITS) equals the weighted sum rounded down.
  assign diff     = $signed({1'b0, y1_i}) - $signed({1'b0, y0_i});
  assign prod     = MW'(diff) * $signed(MW'({1'b0, frac_i}));
  assign sum      = $signed(MW'({1'b0, y0_i})) + (prod >>> PIXEL_BITS);
  assign result_o = sum[15:0];

endmodule

@@ sv/lut_1d_linear_interp_top.sv @@
// Top level of the lookup table interpolator: pipeline, configuration and handshakes.
//
//  Port group     Direction  Handshake            Content
//  in_item_i      in         in_valid_i/ready_o   write entry or map pixel
//  out_item_o     out        out_valid_o/ready_i  mapped value and clip status
//  cfg_*          in         cfg_we_i             low and high bound registers
//
// One item enters per cycle while in_ready_o is high; a pixel result passes through every stage.
// The stages are input register, table read (two registered read ports), output register.
// Write items update the table from the input stage and produce no result.
// A stalled output holds back only the stages behind it; empty stages still fill.
// Reset clears the valid flags and sets the low and high bounds to 0 and 0xFFFF; the table is not cleared.
`include "lut_1d_linear_interp_top_defines.svh"

module lut_1d_linear_interp_top import lji_pkg::*; #(
  parameter int unsigned LUT_DEPTH  = LUT_DEPTH_DEF,
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_item_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i
);

  localparam int unsigned AW = (LUT_DEPTH > 1) ? $clog2(LUT_DEPTH) : 1;
  localparam int unsigned CW = ((AW > 10) ? AW : 10) + 1;

  // Configuration registers.
  logic [15:0] low_bound_q;
  logic [15:0] high_bound_q;

  // Pipeline registers.
  logic                  v1_q;
  in_item_t              item1_q;
  logic                  v2_q;
  logic [PIXEL_BITS-1:0] frac2_q;
  clip_e                 clip2_q;
  logic                  out_valid_q;
  out_item_t             out_item_q;

  // Stage control and datapath signals.
  logic                  s1_is_write;
  logic                  s1_is_pixel;
  logic                  s1_adv;
  logic                  s2_adv;
  logic                  s3_adv;
  logic                  mem_we;
  logic                  mem_re;
  logic [AW-1:0]         x0;
  logic [AW-1:0]         x1;
  logic [PIXEL_BITS-1:0] frac;
  clip_e                 clip;
  logic [15:0]           y0;
  logic [15:0]           y1;
  logic [15:0]           interp_res;
  logic                  interp_in_range;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_bound_q  <= 16'd0;
      high_bound_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOW_BOUND:  low_bound_q  <= cfg_wdata_i;
        REG_HIGH_BOUND: high_bound_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage readiness: a write leaves the input stage without needing the next stage.
  assign s1_is_write = v1_q && (item1_q.opcode == OP_WRITE);
  assign s1_is_pixel = v1_q && (item1_q.opcode == OP_PIXEL);
  assign s3_adv      = !out_valid_q || out_ready_i;
  assign s2_adv      = !v2_q || s3_adv;
  assign s1_adv      = !v1_q || s1_is_write || s2_adv;
  assign in_ready_o  = s1_adv;

  // Input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (s1_adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      item1_q <= in_item_i;
    end
  end

  // Address, fraction and clipping for the pixel in the input stage.
  lji_index #(
    .LUT_DEPTH  (LUT_DEPTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_index (
    .pixel_i      (item1_q.pixel),
    .low_bound_i  (low_bound_q),
    .high_bound_i (high_bound_q),
    .x0_o         (x0),
    .x1_o         (x1),
    .frac_o       (frac),
    .clip_o       (clip)
  );

  // Writes beyond the table are dropped; reads happen as a pixel moves on.
  assign mem_we = s1_is_write && (CW'(item1_q.entry_index) < CW'(LUT_DEPTH));
  assign mem_re = s1_is_pixel && s2_adv;

  lji_mem #(
    .LUT_DEPTH (LUT_DEPTH)
  ) u_mem (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (AW'(item1_q.entry_index)),
    .wdata_i  (item1_q.entry_value),
    .re_i     (mem_re),
    .raddr0_i (x0),
    .raddr1_i (x1),
    .rdata0_o (y0),
    .rdata1_o (y1)
  );

  // Read stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (s2_adv) begin
      v2_q <= s1_is_pixel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      frac2_q <= frac;
      clip2_q <= clip;
    end
  end

  lji_interp #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_interp (
    .y0_i     (y0),
    .y1_i     (y1),
    .frac_i   (frac2_q),
    .result_o (interp_res)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s3_adv) begin
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_adv && v2_q) begin
      out_item_q.mapped_value <= interp_res;
      out_item_q.clip_status  <= clip2_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // The interpolated value must stay within the span of its two neighbours.
  assign interp_in_range = ((interp_res >= y0) && (interp_res <= y1)) ||
                           ((interp_res >= y1) && (interp_res <= y0));

  // A table write and a pixel read never share the input stage.
  `LJI_ASSERT_IMP(a_no_write_read_clash, mem_we, !mem_re)
  // Clipped results carry no fractional weight.
  `LJI_ASSERT_IMP(a_clip_no_frac, v2_q && (clip2_q != CLIP_NONE), frac2_q == '0)
  // A pixel clipped low reads the first entry.
  `LJI_ASSERT_IMP(a_clip_low_addr, s1_is_pixel && (clip == CLIP_LOW), (x0 == '0) && (x1 == '0))
  // The interpolated value lies between its two neighbours.
  `LJI_ASSERT_IMP(a_interp_range, v2_q, interp_in_range)

endmodule
